// File: rtl/core/atr_pkg.sv
package atr_pkg;

  // Default sizes of the table.
  localparam int ENTRIES_DEF     = 16;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int STAMP_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int CMD_W     = 3;
  localparam int NAME_W    = 32;
  localparam int DEV_W     = 16;
  localparam int POLICY_W  = 2;
  localparam int LFSR_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

  // Replacement policies.
  localparam logic [POLICY_W-1:0] POL_FIFO   = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LRU    = 2'd1;
  localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_EXEC  = 3'd1,
    CMD_EVICT = 3'd2,
    CMD_REMH  = 3'd3,
    CMD_REMN  = 3'd4,
    CMD_GETN  = 3'd5,
    CMD_GETD  = 3'd6,
    CMD_FIND  = 3'd7
  } cmd_t;

  // Operations broadcast to every cell.
  typedef enum logic [2:0] {
    CO_NONE,
    CO_WRITE,
    CO_STAMP,
    CO_CLEAR,
    CO_RLOAD,
    CO_RSHIFT,
    CO_RAPPLY
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     skip_zero;
    logic     pos_mode;
  } cell_ctl_t;

  // Which entries compete for the best slot of a search beat.
  typedef enum logic [1:0] {
    FI_ALL,
    FI_NAME,
    FI_SEL
  } filt_t;

  // Status flags carried by a search beat along the chain.
  typedef struct packed {
    logic vld;
    logic hit;
    logic best;
    logic free;
  } probe_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DIV,
    ST_RLOAD,
    ST_RSHIFT,
    ST_RAPPLY,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_MAIN,
    PH_PICK
  } phase_t;

endpackage

// File: rtl/core/allocation_table_replacement_unit.sv
// Each command, but an add with a zero name or device, takes one search beat down the
// chain of ENTRIES cells plus control states; an add makes one more pass per handle it
// finds in use. A stamp wrap adds a rank pass, and a random eviction adds a remainder,
// a rank pass and a second search beat.
// One command at a time; the next is taken while the previous result waits.
// Synchronous active-low reset empties the table at once; no clearing pass is needed.
module allocation_table_replacement_unit #(
  parameter int ENTRIES     = atr_pkg::ENTRIES_DEF,
  parameter int HANDLE_BITS = atr_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = atr_pkg::STAMP_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command, name_tag, device_in, handle_in (from bit 0 up)
  input  logic [((atr_pkg::CMD_W + atr_pkg::NAME_W + atr_pkg::DEV_W + HANDLE_BITS + 7)
                 / 8) * 8 - 1:0]               in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // ok, handle_out, device_out, name_out (from bit 0 up)
  output logic [((1 + HANDLE_BITS + atr_pkg::DEV_W + atr_pkg::NAME_W + 7) / 8) * 8 - 1:0]
                                               out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [atr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [atr_pkg::LFSR_W-1:0]           cfg_data
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int IN_W  = ((atr_pkg::CMD_W + atr_pkg::NAME_W + atr_pkg::DEV_W + HANDLE_BITS + 7)
                          / 8) * 8;
  localparam int OUT_W = ((1 + HANDLE_BITS + atr_pkg::DEV_W + atr_pkg::NAME_W + 7) / 8) * 8;
  localparam int IN_NAME_LO = atr_pkg::CMD_W;
  localparam int IN_DEV_LO  = IN_NAME_LO + atr_pkg::NAME_W;
  localparam int IN_HND_LO  = IN_DEV_LO + atr_pkg::DEV_W;
  localparam int OUT_DEV_LO = 1 + HANDLE_BITS;
  localparam int OUT_NAM_LO = OUT_DEV_LO + atr_pkg::DEV_W;
  localparam int OUT_PAD    = OUT_W - OUT_NAM_LO - atr_pkg::NAME_W;
  localparam logic [IW-1:0] RING_LAST = IW'(ENTRIES - 2);

  // Control state.
  atr_pkg::state_t state_r, state_nxt;
  atr_pkg::phase_t ph_r, ph_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [atr_pkg::POLICY_W-1:0]  policy_r, policy_nxt;
  logic [atr_pkg::LFSR_W-1:0]    lfsr_r, lfsr_nxt;
  logic [HANDLE_BITS-1:0]        next_handle_r, next_handle_nxt;
  logic [STAMP_BITS-1:0]         next_stamp_r, next_stamp_nxt;

  // Command context.
  atr_pkg::cmd_t  cmd_r, cmd_nxt;
  atr_pkg::filt_t filt_r, filt_nxt;
  logic [atr_pkg::NAME_W-1:0] name_r, name_nxt;
  logic [atr_pkg::DEV_W-1:0]  dev_r, dev_nxt;
  logic [HANDLE_BITS-1:0]     hin_r, hin_nxt;
  logic [HANDLE_BITS-1:0]     qh_r, qh_nxt;
  logic                       use_hit_r, use_hit_nxt;
  logic [IW-1:0]              qsel_r, qsel_nxt;
  logic                       ring_pos_r, ring_pos_nxt;
  logic                       skip_r, skip_nxt;
  logic [IW-1:0]              ring_cnt_r, ring_cnt_nxt;
  logic [CW-1:0]              nelig_r, nelig_nxt;

  // Pending result and output register.
  logic                       res_ok_r, res_ok_nxt;
  logic [HANDLE_BITS-1:0]     res_h_r, res_h_nxt;
  logic [atr_pkg::DEV_W-1:0]  res_d_r, res_d_nxt;
  logic [atr_pkg::NAME_W-1:0] res_n_r, res_n_nxt;
  logic                       out_ok_r, out_ok_nxt;
  logic [HANDLE_BITS-1:0]     out_h_r, out_h_nxt;
  logic [atr_pkg::DEV_W-1:0]  out_d_r, out_d_nxt;
  logic [atr_pkg::NAME_W-1:0] out_n_r, out_n_nxt;

  // Cell control.
  atr_pkg::cell_ctl_t     ctl;
  logic [IW-1:0]          ctl_idx;
  logic [HANDLE_BITS-1:0] wr_handle;
  logic [STAMP_BITS-1:0]  wr_stamp;
  logic                   inject;
  logic                   div_start;
  logic                   div_done;
  logic [IW-1:0]          div_rem;

  // Search chain taps and rank ring.
  atr_pkg::probe_flags_t      pf          [ENTRIES+1];
  logic [IW-1:0]              p_hit_idx   [ENTRIES+1];
  logic [IW-1:0]              p_best_idx  [ENTRIES+1];
  logic [STAMP_BITS-1:0]      p_best_stamp[ENTRIES+1];
  logic [HANDLE_BITS-1:0]     p_best_hnd  [ENTRIES+1];
  logic [CW-1:0]              p_nvalid    [ENTRIES+1];
  logic [IW-1:0]              p_free_idx  [ENTRIES+1];
  logic [HANDLE_BITS-1:0]     p_o_handle  [ENTRIES+1];
  logic [atr_pkg::NAME_W-1:0] p_o_name    [ENTRIES+1];
  logic [atr_pkg::DEV_W-1:0]  p_o_dev     [ENTRIES+1];
  logic                       r_elig      [ENTRIES];
  logic [STAMP_BITS-1:0]      r_stamp     [ENTRIES];
  logic [HANDLE_BITS-1:0]     r_handle    [ENTRIES];

  // Helpers.
  logic [HANDLE_BITS-1:0]     qh_plus;
  logic [HANDLE_BITS-1:0]     qh_inc;
  logic [HANDLE_BITS-1:0]     start_h;
  logic [STAMP_BITS-1:0]      ns_inc;
  logic [CW-1:0]              n_final;
  logic [atr_pkg::LFSR_W-1:0] lfsr_step;
  logic                       stamp_zero;
  logic                       in_fire;
  atr_pkg::cmd_t              in_cmd;
  logic [atr_pkg::NAME_W-1:0] in_name;
  logic [atr_pkg::DEV_W-1:0]  in_dev;
  logic [HANDLE_BITS-1:0]     in_hnd;

  assign in_cmd  = atr_pkg::cmd_t'(in_tdata[atr_pkg::CMD_W-1:0]);
  assign in_name = in_tdata[IN_NAME_LO +: atr_pkg::NAME_W];
  assign in_dev  = in_tdata[IN_DEV_LO +: atr_pkg::DEV_W];
  assign in_hnd  = in_tdata[IN_HND_LO +: HANDLE_BITS];
  assign in_fire = in_tvalid && in_tready;

  assign qh_plus    = qh_r + HANDLE_BITS'(1);
  assign qh_inc     = (qh_plus == '0) ? HANDLE_BITS'(1) : qh_plus;
  assign start_h    = (next_handle_r == '0) ? HANDLE_BITS'(1) : next_handle_r;
  assign ns_inc     = next_stamp_r + STAMP_BITS'(1);
  assign n_final    = nelig_r + CW'(r_elig[ENTRIES-1]);
  assign lfsr_step  = {1'b0, lfsr_r[atr_pkg::LFSR_W-1:1]} ^
                      (lfsr_r[0] ? atr_pkg::LFSR_TAPS : '0);
  assign stamp_zero = (policy_r == atr_pkg::POL_LRU) || (policy_r == atr_pkg::POL_RANDOM);

  // Head of the search chain.
  assign pf[0]           = '{vld: inject, hit: 1'b0, best: 1'b0, free: 1'b0};
  assign p_hit_idx[0]    = '0;
  assign p_best_idx[0]   = '0;
  assign p_best_stamp[0] = '0;
  assign p_best_hnd[0]   = '0;
  assign p_nvalid[0]     = '0;
  assign p_free_idx[0]   = '0;
  assign p_o_handle[0]   = '0;
  assign p_o_name[0]     = '0;
  assign p_o_dev[0]      = '0;

  // The row of entry cells.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    localparam int PREV = (k == 0) ? ENTRIES - 1 : k - 1;
    atr_cell #(
      .ENTRIES    (ENTRIES),
      .HANDLE_BITS(HANDLE_BITS),
      .STAMP_BITS (STAMP_BITS),
      .INDEX      (k)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .sel           (ctl_idx == IW'(k)),
      .wr_handle     (wr_handle),
      .wr_name       (name_r),
      .wr_device     (dev_r),
      .wr_stamp      (wr_stamp),
      .q_handle      (qh_r),
      .q_name        (name_r),
      .q_filt        (filt_r),
      .q_sel         (qsel_r),
      .q_use_hit     (use_hit_r),
      .pi_f          (pf[k]),
      .pi_hit_idx    (p_hit_idx[k]),
      .pi_best_idx   (p_best_idx[k]),
      .pi_best_stamp (p_best_stamp[k]),
      .pi_best_handle(p_best_hnd[k]),
      .pi_nvalid     (p_nvalid[k]),
      .pi_free_idx   (p_free_idx[k]),
      .pi_o_handle   (p_o_handle[k]),
      .pi_o_name     (p_o_name[k]),
      .pi_o_dev      (p_o_dev[k]),
      .po_f          (pf[k+1]),
      .po_hit_idx    (p_hit_idx[k+1]),
      .po_best_idx   (p_best_idx[k+1]),
      .po_best_stamp (p_best_stamp[k+1]),
      .po_best_handle(p_best_hnd[k+1]),
      .po_nvalid     (p_nvalid[k+1]),
      .po_free_idx   (p_free_idx[k+1]),
      .po_o_handle   (p_o_handle[k+1]),
      .po_o_name     (p_o_name[k+1]),
      .po_o_dev      (p_o_dev[k+1]),
      .ri_elig       (r_elig[PREV]),
      .ri_stamp      (r_stamp[PREV]),
      .ri_handle     (r_handle[PREV]),
      .ro_elig       (r_elig[k]),
      .ro_stamp      (r_stamp[k]),
      .ro_handle     (r_handle[k])
    );
  end

  // Remainder unit for the random pick.
  atr_mod #(
    .ENTRIES(ENTRIES)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(lfsr_nxt),
    .divisor (p_nvalid[ENTRIES]),
    .done    (div_done),
    .rem     (div_rem)
  );

  assign in_tready  = (state_r == atr_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_n_r, out_d_r, out_h_r, out_ok_r};

  // Sequencer: next state, cell commands and result.
  always_comb begin
    state_nxt       = state_r;
    ph_nxt          = ph_r;
    policy_nxt      = policy_r;
    lfsr_nxt        = lfsr_r;
    next_handle_nxt = next_handle_r;
    next_stamp_nxt  = next_stamp_r;
    cmd_nxt         = cmd_r;
    filt_nxt        = filt_r;
    name_nxt        = name_r;
    dev_nxt         = dev_r;
    hin_nxt         = hin_r;
    qh_nxt          = qh_r;
    use_hit_nxt     = use_hit_r;
    qsel_nxt        = qsel_r;
    ring_pos_nxt    = ring_pos_r;
    skip_nxt        = skip_r;
    ring_cnt_nxt    = ring_cnt_r;
    nelig_nxt       = nelig_r;
    res_ok_nxt      = res_ok_r;
    res_h_nxt       = res_h_r;
    res_d_nxt       = res_d_r;
    res_n_nxt       = res_n_r;
    out_valid_nxt   = out_valid_r;
    out_ok_nxt      = out_ok_r;
    out_h_nxt       = out_h_r;
    out_d_nxt       = out_d_r;
    out_n_nxt       = out_n_r;
    ctl             = '{op: atr_pkg::CO_NONE, skip_zero: skip_r, pos_mode: ring_pos_r};
    ctl_idx         = '0;
    wr_handle       = qh_r;
    wr_stamp        = next_stamp_r;
    inject          = 1'b0;
    div_start       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      atr_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = in_cmd;
          name_nxt    = in_name;
          dev_nxt     = in_dev;
          hin_nxt     = in_hnd;
          qh_nxt      = (in_cmd == atr_pkg::CMD_ADD) ? start_h : in_hnd;
          filt_nxt    = ((in_cmd == atr_pkg::CMD_REMN) || (in_cmd == atr_pkg::CMD_FIND)) ?
                        atr_pkg::FI_NAME : atr_pkg::FI_ALL;
          use_hit_nxt = (in_cmd == atr_pkg::CMD_EXEC) || (in_cmd == atr_pkg::CMD_REMH) ||
                        (in_cmd == atr_pkg::CMD_GETN) || (in_cmd == atr_pkg::CMD_GETD);
          ph_nxt      = atr_pkg::PH_MAIN;
          res_ok_nxt  = 1'b0;
          res_h_nxt   = '0;
          res_d_nxt   = '0;
          res_n_nxt   = '0;
          if ((in_cmd == atr_pkg::CMD_ADD) && ((in_dev == '0) || (in_name == '0))) begin
            state_nxt = atr_pkg::ST_DONE;
          end else begin
            state_nxt = atr_pkg::ST_ISSUE;
          end
        end
      end

      atr_pkg::ST_ISSUE: begin
        inject    = 1'b1;
        state_nxt = atr_pkg::ST_WAIT;
      end

      atr_pkg::ST_WAIT: begin
        if (pf[ENTRIES].vld) begin
          state_nxt = atr_pkg::ST_DONE;
          unique case (cmd_r)
            atr_pkg::CMD_ADD: begin
              if (pf[ENTRIES].free && pf[ENTRIES].hit) begin
                // Handle in use: try the next one.
                qh_nxt    = qh_inc;
                state_nxt = atr_pkg::ST_ISSUE;
              end else if (pf[ENTRIES].free) begin
                ctl.op          = atr_pkg::CO_WRITE;
                ctl_idx         = p_free_idx[ENTRIES];
                wr_stamp        = stamp_zero ? '0 : next_stamp_r;
                next_handle_nxt = qh_plus;
                res_ok_nxt      = 1'b1;
                res_h_nxt       = qh_r;
                if (!stamp_zero) begin
                  next_stamp_nxt = ns_inc;
                  if (ns_inc == '0) begin
                    skip_nxt     = 1'b0;
                    ring_pos_nxt = 1'b0;
                    state_nxt    = atr_pkg::ST_RLOAD;
                  end
                end
              end
            end
            atr_pkg::CMD_EXEC: begin
              if (pf[ENTRIES].hit) begin
                res_ok_nxt = 1'b1;
                res_h_nxt  = hin_r;
                if (policy_r == atr_pkg::POL_LRU) begin
                  ctl.op         = atr_pkg::CO_STAMP;
                  ctl_idx        = p_hit_idx[ENTRIES];
                  next_stamp_nxt = ns_inc;
                  if (ns_inc == '0) begin
                    skip_nxt     = 1'b1;
                    ring_pos_nxt = 1'b0;
                    state_nxt    = atr_pkg::ST_RLOAD;
                  end
                end
              end
            end
            atr_pkg::CMD_EVICT: begin
              if ((policy_r == atr_pkg::POL_RANDOM) && (ph_r == atr_pkg::PH_MAIN)) begin
                if (p_nvalid[ENTRIES] != '0) begin
                  lfsr_nxt  = lfsr_step;
                  div_start = 1'b1;
                  state_nxt = atr_pkg::ST_DIV;
                end
              end else if (pf[ENTRIES].best) begin
                ctl.op     = atr_pkg::CO_CLEAR;
                ctl_idx    = p_best_idx[ENTRIES];
                res_ok_nxt = 1'b1;
                res_h_nxt  = p_o_handle[ENTRIES];
                res_d_nxt  = p_o_dev[ENTRIES];
              end
            end
            atr_pkg::CMD_REMH: begin
              if (pf[ENTRIES].hit) begin
                ctl.op     = atr_pkg::CO_CLEAR;
                ctl_idx    = p_hit_idx[ENTRIES];
                res_ok_nxt = 1'b1;
                res_h_nxt  = p_o_handle[ENTRIES];
                res_d_nxt  = p_o_dev[ENTRIES];
              end
            end
            atr_pkg::CMD_REMN: begin
              if (pf[ENTRIES].best) begin
                ctl.op     = atr_pkg::CO_CLEAR;
                ctl_idx    = p_best_idx[ENTRIES];
                res_ok_nxt = 1'b1;
                res_h_nxt  = p_o_handle[ENTRIES];
                res_d_nxt  = p_o_dev[ENTRIES];
              end
            end
            atr_pkg::CMD_GETN: begin
              if (pf[ENTRIES].hit) begin
                res_ok_nxt = 1'b1;
                res_h_nxt  = hin_r;
                res_n_nxt  = p_o_name[ENTRIES];
              end
            end
            atr_pkg::CMD_GETD: begin
              if (pf[ENTRIES].hit) begin
                res_ok_nxt = 1'b1;
                res_h_nxt  = hin_r;
                res_d_nxt  = p_o_dev[ENTRIES];
              end
            end
            atr_pkg::CMD_FIND: begin
              if (pf[ENTRIES].best) begin
                res_ok_nxt = 1'b1;
                res_h_nxt  = p_o_handle[ENTRIES];
              end
            end
            default: ;
          endcase
        end
      end

      atr_pkg::ST_DIV: begin
        if (div_done) begin
          qsel_nxt     = div_rem;
          skip_nxt     = 1'b0;
          ring_pos_nxt = 1'b1;
          state_nxt    = atr_pkg::ST_RLOAD;
        end
      end

      atr_pkg::ST_RLOAD: begin
        ctl.op       = atr_pkg::CO_RLOAD;
        nelig_nxt    = '0;
        ring_cnt_nxt = '0;
        state_nxt    = atr_pkg::ST_RSHIFT;
      end

      // Keys travel once round the ring; the key leaving the last cell is counted.
      atr_pkg::ST_RSHIFT: begin
        ctl.op       = atr_pkg::CO_RSHIFT;
        nelig_nxt    = n_final;
        ring_cnt_nxt = ring_cnt_r + IW'(1);
        if (ring_cnt_r == RING_LAST) begin
          state_nxt = atr_pkg::ST_RAPPLY;
        end
      end

      atr_pkg::ST_RAPPLY: begin
        if (ring_pos_r) begin
          ph_nxt    = atr_pkg::PH_PICK;
          filt_nxt  = atr_pkg::FI_SEL;
          state_nxt = atr_pkg::ST_ISSUE;
        end else begin
          ctl.op         = atr_pkg::CO_RAPPLY;
          next_stamp_nxt = STAMP_BITS'({1'b0, n_final} + 1'b1);
          state_nxt      = atr_pkg::ST_DONE;
        end
      end

      atr_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_h_nxt     = res_h_r;
          out_d_nxt     = res_d_r;
          out_n_nxt     = res_n_r;
          state_nxt     = atr_pkg::ST_IDLE;
        end
      end

      default: state_nxt = atr_pkg::ST_IDLE;
    endcase

    // Configuration writes.
    if (cfg_valid) begin
      unique case (cfg_index)
        atr_pkg::CFG_POLICY: policy_nxt = cfg_data[atr_pkg::POLICY_W-1:0];
        atr_pkg::CFG_SEED:   lfsr_nxt   = (cfg_data == '0) ? atr_pkg::LFSR_W'(1) : cfg_data;
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= atr_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      policy_r      <= atr_pkg::POL_FIFO;
      lfsr_r        <= atr_pkg::SEED_RESET;
      next_handle_r <= HANDLE_BITS'(1);
      next_stamp_r  <= STAMP_BITS'(1);
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      policy_r      <= policy_nxt;
      lfsr_r        <= lfsr_nxt;
      next_handle_r <= next_handle_nxt;
      next_stamp_r  <= next_stamp_nxt;
    end
  end

  // Command context and result registers.
  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    cmd_r      <= cmd_nxt;
    filt_r     <= filt_nxt;
    name_r     <= name_nxt;
    dev_r      <= dev_nxt;
    hin_r      <= hin_nxt;
    qh_r       <= qh_nxt;
    use_hit_r  <= use_hit_nxt;
    qsel_r     <= qsel_nxt;
    ring_pos_r <= ring_pos_nxt;
    skip_r     <= skip_nxt;
    ring_cnt_r <= ring_cnt_nxt;
    nelig_r    <= nelig_nxt;
    res_ok_r   <= res_ok_nxt;
    res_h_r    <= res_h_nxt;
    res_d_r    <= res_d_nxt;
    res_n_r    <= res_n_nxt;
    out_ok_r   <= out_ok_nxt;
    out_h_r    <= out_h_nxt;
    out_d_r    <= out_d_nxt;
    out_n_r    <= out_n_nxt;
  end

  // A search beat leaves the chain only while the sequencer waits for it.
  a_beat_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    pf[ENTRIES].vld |-> (state_r == atr_pkg::ST_WAIT))
    else $error("search beat left the chain outside the wait state");

  // The remainder unit finishes only while the sequencer waits on it.
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == atr_pkg::ST_DIV))
    else $error("remainder finished outside the division state");

  // A handle hit implies at least one valid entry was counted.
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (pf[ENTRIES].vld && pf[ENTRIES].hit) |-> (p_nvalid[ENTRIES] != '0))
    else $error("handle hit with no valid entry counted");

endmodule

// File: rtl/core/atr_cell.sv
module atr_cell #(
  parameter int ENTRIES     = atr_pkg::ENTRIES_DEF,
  parameter int HANDLE_BITS = atr_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = atr_pkg::STAMP_BITS_DEF,
  parameter int INDEX       = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  atr_pkg::cell_ctl_t             ctl,
  input  logic                           sel,
  input  logic [HANDLE_BITS-1:0]         wr_handle,
  input  logic [atr_pkg::NAME_W-1:0]     wr_name,
  input  logic [atr_pkg::DEV_W-1:0]      wr_device,
  input  logic [STAMP_BITS-1:0]          wr_stamp,
  input  logic [HANDLE_BITS-1:0]         q_handle,
  input  logic [atr_pkg::NAME_W-1:0]     q_name,
  input  atr_pkg::filt_t                 q_filt,
  input  logic [$clog2(ENTRIES)-1:0]     q_sel,
  input  logic                           q_use_hit,
  input  atr_pkg::probe_flags_t          pi_f,
  input  logic [$clog2(ENTRIES)-1:0]     pi_hit_idx,
  input  logic [$clog2(ENTRIES)-1:0]     pi_best_idx,
  input  logic [STAMP_BITS-1:0]          pi_best_stamp,
  input  logic [HANDLE_BITS-1:0]         pi_best_handle,
  input  logic [$clog2(ENTRIES+1)-1:0]   pi_nvalid,
  input  logic [$clog2(ENTRIES)-1:0]     pi_free_idx,
  input  logic [HANDLE_BITS-1:0]         pi_o_handle,
  input  logic [atr_pkg::NAME_W-1:0]     pi_o_name,
  input  logic [atr_pkg::DEV_W-1:0]      pi_o_dev,
  output atr_pkg::probe_flags_t          po_f,
  output logic [$clog2(ENTRIES)-1:0]     po_hit_idx,
  output logic [$clog2(ENTRIES)-1:0]     po_best_idx,
  output logic [STAMP_BITS-1:0]          po_best_stamp,
  output logic [HANDLE_BITS-1:0]         po_best_handle,
  output logic [$clog2(ENTRIES+1)-1:0]   po_nvalid,
  output logic [$clog2(ENTRIES)-1:0]     po_free_idx,
  output logic [HANDLE_BITS-1:0]         po_o_handle,
  output logic [atr_pkg::NAME_W-1:0]     po_o_name,
  output logic [atr_pkg::DEV_W-1:0]      po_o_dev,
  input  logic                           ri_elig,
  input  logic [STAMP_BITS-1:0]          ri_stamp,
  input  logic [HANDLE_BITS-1:0]         ri_handle,
  output logic                           ro_elig,
  output logic [STAMP_BITS-1:0]          ro_stamp,
  output logic [HANDLE_BITS-1:0]         ro_handle
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic                       v_r;
  logic [HANDLE_BITS-1:0]     h_r;
  logic [atr_pkg::NAME_W-1:0] n_r;
  logic [atr_pkg::DEV_W-1:0]  d_r;
  logic [STAMP_BITS-1:0]      s_r;
  logic                       rk_elig_r;
  logic [STAMP_BITS-1:0]      rk_stamp_r;
  logic [HANDLE_BITS-1:0]     rk_handle_r;
  logic [IW-1:0]              cnt_r;
  logic                       own_elig_r;

  logic                  key_elig;
  logic [STAMP_BITS-1:0] key_stamp;
  logic                  ring_less;
  logic                  match_h;
  logic                  cand;
  logic                  better;
  logic                  take;

  // Own key for ranking: stamp and handle, or handle alone when placing by handle.
  assign key_elig  = v_r && !(ctl.skip_zero && (s_r == '0));
  assign key_stamp = ctl.pos_mode ? '0 : s_r;
  assign ring_less = (ri_stamp < key_stamp) ||
                     ((ri_stamp == key_stamp) && (ri_handle < h_r));

  // Valid flag of the entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (sel && (ctl.op == atr_pkg::CO_WRITE)) begin
      v_r <= 1'b1;
    end else if (sel && (ctl.op == atr_pkg::CO_CLEAR)) begin
      v_r <= 1'b0;
    end
  end

  // Entry contents and the rank ring.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      atr_pkg::CO_WRITE: begin
        if (sel) begin
          h_r <= wr_handle;
          n_r <= wr_name;
          d_r <= wr_device;
          s_r <= wr_stamp;
        end
      end
      atr_pkg::CO_STAMP: begin
        if (sel) begin
          s_r <= wr_stamp;
        end
      end
      atr_pkg::CO_RLOAD: begin
        rk_elig_r   <= key_elig;
        rk_stamp_r  <= key_stamp;
        rk_handle_r <= h_r;
        own_elig_r  <= key_elig;
        cnt_r       <= '0;
      end
      atr_pkg::CO_RSHIFT: begin
        rk_elig_r   <= ri_elig;
        rk_stamp_r  <= ri_stamp;
        rk_handle_r <= ri_handle;
        if (ri_elig && ring_less) begin
          cnt_r <= cnt_r + IW'(1);
        end
      end
      atr_pkg::CO_RAPPLY: begin
        if (own_elig_r) begin
          s_r <= STAMP_BITS'({1'b0, cnt_r} + 1'b1);
        end
      end
      default: ;
    endcase
  end

  assign ro_elig   = rk_elig_r;
  assign ro_stamp  = rk_stamp_r;
  assign ro_handle = rk_handle_r;

  // Search beat: compare this entry against what the beat carries.
  always_comb begin
    match_h = v_r && (h_r == q_handle);
    unique case (q_filt)
      atr_pkg::FI_ALL:  cand = v_r;
      atr_pkg::FI_NAME: cand = v_r && (q_name != '0) && (n_r == q_name);
      atr_pkg::FI_SEL:  cand = v_r && (cnt_r == q_sel);
      default:          cand = 1'b0;
    endcase
    better = cand && (!pi_f.best || (s_r < pi_best_stamp) ||
                      ((s_r == pi_best_stamp) && (h_r < pi_best_handle)));
    take   = q_use_hit ? match_h : better;
  end

  // Hand the beat on to the next cell; only its valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      po_f.vld <= 1'b0;
    end else begin
      po_f.vld <= pi_f.vld;
    end
    po_f.hit       <= pi_f.hit || match_h;
    po_hit_idx     <= match_h ? MY_IDX : pi_hit_idx;
    po_f.best      <= pi_f.best || better;
    po_best_idx    <= better ? MY_IDX : pi_best_idx;
    po_best_stamp  <= better ? s_r : pi_best_stamp;
    po_best_handle <= better ? h_r : pi_best_handle;
    po_nvalid      <= pi_nvalid + CW'(v_r);
    po_f.free      <= pi_f.free || !v_r;
    po_free_idx    <= (!pi_f.free && !v_r) ? MY_IDX : pi_free_idx;
    po_o_handle    <= take ? h_r : pi_o_handle;
    po_o_name      <= take ? n_r : pi_o_name;
    po_o_dev       <= take ? d_r : pi_o_dev;
  end

endmodule

// File: rtl/core/atr_mod.sv
module atr_mod #(
  parameter int ENTRIES = atr_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [atr_pkg::LFSR_W-1:0]   dividend,
  input  logic [$clog2(ENTRIES+1)-1:0] divisor,
  output logic                         done,
  output logic [$clog2(ENTRIES)-1:0]   rem
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = $clog2(atr_pkg::LFSR_W);
  localparam logic [SW-1:0] LAST = SW'(atr_pkg::LFSR_W - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [SW-1:0]              step_r;
  logic [atr_pkg::LFSR_W-1:0] dvd_r;
  logic [CW-1:0]              rem_r;
  logic [CW-1:0]              dsr_r;
  logic [CW:0]                trial;
  logic                       ge;

  // One restoring step a cycle, most significant dividend bit first.
  assign trial = {rem_r, dvd_r[atr_pkg::LFSR_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == LAST)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[atr_pkg::LFSR_W-2:0], 1'b0};
      rem_r  <= ge ? CW'(trial - {1'b0, dsr_r}) : CW'(trial);
      step_r <= step_r + SW'(1);
    end
  end

  assign done = done_r;
  assign rem  = rem_r[IW-1:0];

endmodule

// File: tb/allocation_table_replacement_unit_tb.sv
module allocation_table_replacement_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = atr_pkg::ENTRIES_DEF;
  localparam int IN_W  = ((atr_pkg::CMD_W + atr_pkg::NAME_W + atr_pkg::DEV_W +
                           atr_pkg::HANDLE_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((1 + atr_pkg::HANDLE_BITS_DEF + atr_pkg::DEV_W + atr_pkg::NAME_W + 7)
                          / 8) * 8;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [atr_pkg::NAME_W-1:0] name;
    logic [atr_pkg::DEV_W-1:0]  dev;
    logic [15:0]                hnd;
    logic                       ok;
  } reply_t;

  // Model of the table: slot contents, counters and policy registers.
  class table_scoreboard;
    bit          valid [NSLOT];
    bit [15:0]   hnd [NSLOT];
    bit [31:0]   name [NSLOT];
    bit [15:0]   dev [NSLOT];
    bit [15:0]   stamp [NSLOT];
    bit [15:0]   next_hnd;
    bit [15:0]   next_stamp;
    bit [15:0]   lfsr;
    bit [1:0]    policy;
    reply_t      pending [$];
    int          errors;
    int          checked;
    int          hits;

    function new();
      foreach (valid[i]) valid[i] = 0;
      next_hnd = 1;
      next_stamp = 1;
      lfsr = atr_pkg::SEED_RESET;
      policy = atr_pkg::POL_FIFO;
      errors = 0;
      checked = 0;
      hits = 0;
    endfunction

    function void write_reg(bit idx, bit [15:0] val);
      if (idx == atr_pkg::CFG_POLICY) policy = val[1:0];
      else lfsr = (val != 0) ? val : 16'd1;
    endfunction

    function bit older(int a, int b);
      if (stamp[a] != stamp[b]) return stamp[a] < stamp[b];
      return hnd[a] < hnd[b];
    endfunction

    function int slot_of(bit [15:0] h);
      for (int i = 0; i < NSLOT; i++) if (valid[i] && hnd[i] == h) return i;
      return -1;
    endfunction

    function int slot_by_name(bit [31:0] n);
      int best;
      best = -1;
      if (n == 0) return -1;
      for (int i = 0; i < NSLOT; i++)
        if (valid[i] && name[i] == n && (best < 0 || older(i, best))) best = i;
      return best;
    endfunction

    // Give a slot the next stamp; on wrap, rank the stamped entries afresh.
    function void restamp(int s, bit skip_zero);
      int rank [NSLOT];
      int n;
      stamp[s] = next_stamp;
      next_stamp++;
      if (next_stamp != 0) return;
      n = 0;
      for (int i = 0; i < NSLOT; i++) begin
        rank[i] = 0;
        if (!valid[i] || (skip_zero && stamp[i] == 0)) continue;
        n++;
        rank[i] = 1;
        for (int j = 0; j < NSLOT; j++) begin
          if (j == i || !valid[j] || (skip_zero && stamp[j] == 0)) continue;
          if (older(j, i)) rank[i]++;
        end
      end
      for (int i = 0; i < NSLOT; i++) if (rank[i] != 0) stamp[i] = 16'(rank[i]);
      next_stamp = 16'(n + 1);
    endfunction

    function int victim();
      int best, cnt, idx, pos;
      best = -1;
      cnt = 0;
      foreach (valid[i]) if (valid[i]) cnt++;
      if (cnt == 0) return -1;
      if (policy != atr_pkg::POL_RANDOM) begin
        for (int i = 0; i < NSLOT; i++)
          if (valid[i] && (best < 0 || older(i, best))) best = i;
        return best;
      end
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ atr_pkg::LFSR_TAPS) : (lfsr >> 1);
      idx = lfsr % cnt;
      for (int i = 0; i < NSLOT; i++) begin
        if (!valid[i]) continue;
        pos = 0;
        for (int j = 0; j < NSLOT; j++) if (valid[j] && hnd[j] < hnd[i]) pos++;
        if (pos == idx) return i;
      end
      return -1;
    endfunction

    // Work out the reply to one accepted command and queue it.
    function void note_command(atr_pkg::cmd_t c, bit [31:0] n, bit [15:0] d, bit [15:0] h);
      reply_t r;
      int s, guard;
      bit [15:0] nh;
      r = '0;
      case (c)
        atr_pkg::CMD_ADD: begin
          s = -1;
          for (int i = 0; i < NSLOT; i++) if (!valid[i]) begin s = i; break; end
          if (d != 0 && n != 0 && s >= 0) begin
            nh = (next_hnd == 0) ? 16'd1 : next_hnd;
            for (guard = 0; guard < NSLOT + 2 && slot_of(nh) >= 0; guard++) begin
              nh++;
              if (nh == 0) nh = 1;
            end
            if (slot_of(nh) < 0) begin
              valid[s] = 1; hnd[s] = nh; name[s] = n; dev[s] = d;
              if (policy == atr_pkg::POL_LRU || policy == atr_pkg::POL_RANDOM) stamp[s] = 0;
              else restamp(s, 0);
              next_hnd = nh + 16'd1;
              r.ok = 1; r.hnd = nh;
            end
          end
        end
        atr_pkg::CMD_EXEC: begin
          s = slot_of(h);
          if (s >= 0) begin
            if (policy == atr_pkg::POL_LRU) restamp(s, 1);
            r.ok = 1; r.hnd = h;
          end
        end
        atr_pkg::CMD_EVICT, atr_pkg::CMD_REMH, atr_pkg::CMD_REMN: begin
          s = (c == atr_pkg::CMD_EVICT) ? victim() :
              (c == atr_pkg::CMD_REMH) ? slot_of(h) : slot_by_name(n);
          if (s >= 0) begin
            valid[s] = 0;
            r.ok = 1; r.hnd = hnd[s]; r.dev = dev[s];
          end
        end
        atr_pkg::CMD_GETN: begin
          s = slot_of(h);
          if (s >= 0) begin r.ok = 1; r.hnd = h; r.name = name[s]; end
        end
        atr_pkg::CMD_GETD: begin
          s = slot_of(h);
          if (s >= 0) begin r.ok = 1; r.hnd = h; r.dev = dev[s]; end
        end
        default: begin
          s = slot_by_name(n);
          if (s >= 0) begin r.ok = 1; r.hnd = hnd[s]; end
        end
      endcase
      if (r.ok) hits++;
      pending.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected reply %h", $realtime, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.ok !== exp.ok) begin
        $display("%0t: ok expected %0d actual %0d", $realtime, exp.ok, got.ok); errors++;
      end
      if (got.hnd !== exp.hnd) begin
        $display("%0t: handle expected %h actual %h", $realtime, exp.hnd, got.hnd); errors++;
      end
      if (got.dev !== exp.dev) begin
        $display("%0t: device expected %h actual %h", $realtime, exp.dev, got.dev); errors++;
      end
      if (got.name !== exp.name) begin
        $display("%0t: name expected %h actual %h", $realtime, exp.name, got.name); errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [atr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [atr_pkg::LFSR_W-1:0]    cfg_data;

  table_scoreboard sb;
  int  idle_cycles;
  int  cmds_sent;
  bit  hold_off;

  allocation_table_replacement_unit dut (
    .clk, .rst_n,
    .in_tdata, .in_tvalid, .in_tready,
    .out_tdata, .out_tvalid, .out_tready,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Monitor: score accepted commands and replies, and run the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_command(atr_pkg::cmd_t'(in_tdata[2:0]), in_tdata[34:3], in_tdata[50:35],
                        in_tdata[66:51]);
      if (out_tvalid && out_tready)
        sb.check_reply(reply_t'({out_tdata[64:33], out_tdata[32:17], out_tdata[16:1],
                                 out_tdata[0]}));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d replies outstanding", sb.pending.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random ready, with one long hold-off when asked.
  initial begin
    int g;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  // The beat stays offered until the next command or drain takes valid down.
  task automatic send_cmd(atr_pkg::cmd_t c, bit [31:0] n, bit [15:0] d, bit [15:0] h);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tdata  <= IN_W'({h, d, n, c});
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    cmds_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_cfg(bit idx, bit [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Handle picked mostly from those issued lately, sometimes at random.
  function automatic bit [15:0] pick_handle();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return sb.next_hnd - 16'($urandom_range(1, 20));
    if (p < 8) return 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  // Name drawn from a small pool so lookups by name often hit duplicates.
  function automatic bit [31:0] pick_name();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return 32'($urandom_range(1, 6)) << ($urandom_range(0, 1) * 28);
    if (p < 8) return 0;
    return $urandom;
  endfunction

  task automatic random_phase(int count);
    int p;
    atr_pkg::cmd_t c;
    bit [15:0] d;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      c = (p < 35) ? atr_pkg::CMD_ADD : (p < 50) ? atr_pkg::CMD_EXEC :
          (p < 62) ? atr_pkg::CMD_EVICT : atr_pkg::cmd_t'($urandom_range(3, 7));
      d = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
      if (c == atr_pkg::CMD_ADD && d == 0 && $urandom_range(0, 1)) d = 16'hFFFF;
      send_cmd(c, pick_name(), d, pick_handle());
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0;
    cfg_valid = 0; cfg_index = atr_pkg::CFG_POLICY; cfg_data = '0;
    idle_cycles = 0; cmds_sent = 0; hold_off = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: invalid adds, table full, handle extremes, every command at least once.
    send_cmd(atr_pkg::CMD_EVICT, 0, 0, 0);
    send_cmd(atr_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'd0, 0);
    send_cmd(atr_pkg::CMD_ADD, 32'd0, 16'hFFFF, 0);
    for (int k = 0; k < NSLOT + 1; k++)
      send_cmd(atr_pkg::CMD_ADD, (k % 2) ? 32'hFFFF_FFFF : 32'd7, 16'(k + 1), 0);
    send_cmd(atr_pkg::CMD_EXEC, 0, 0, 16'd3);
    send_cmd(atr_pkg::CMD_EXEC, 0, 0, 16'hFFFF);
    send_cmd(atr_pkg::CMD_REMN, 32'hFFFF_FFFF, 0, 0);
    send_cmd(atr_pkg::CMD_REMN, 32'd0, 0, 0);
    send_cmd(atr_pkg::CMD_FIND, 32'd7, 0, 0);
    send_cmd(atr_pkg::CMD_GETN, 0, 0, 16'd2);
    send_cmd(atr_pkg::CMD_GETD, 0, 0, 16'd2);
    send_cmd(atr_pkg::CMD_REMH, 0, 0, 16'd5);
    drain();

    // Long receiver stall while the sender keeps offering commands.
    hold_off = 1;
    random_phase(40);
    drain();

    // Walk through the policies and seeds, extremes included.
    write_cfg(atr_pkg::CFG_POLICY, atr_pkg::POL_LRU);
    write_cfg(atr_pkg::CFG_SEED, 16'd1);
    random_phase(350);
    drain();
    write_cfg(atr_pkg::CFG_POLICY, atr_pkg::POL_RANDOM);
    random_phase(350);
    drain();
    write_cfg(atr_pkg::CFG_SEED, 16'hFFFF);
    random_phase(250);
    drain();
    write_cfg(atr_pkg::CFG_SEED, 16'($urandom_range(1, 65535)));
    write_cfg(atr_pkg::CFG_POLICY, 2'd3);
    random_phase(200);
    drain();
    write_cfg(atr_pkg::CFG_POLICY, atr_pkg::POL_FIFO);
    write_cfg(atr_pkg::CFG_SEED, 16'd0);
    random_phase(370);
    drain();

    $display("Sent %0d commands, checked %0d replies (%0d successful) across all policies.",
             cmds_sent, sb.checked, sb.hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
